FILE: rtl/dis_pkg.sv
// Shared types and constants for the disjoint interval set block.
// No dependencies; imported by the entry compare unit and the top level.
package dis_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int VALUE_BITS_DEF    = 31;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_MEX    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_REVERSED = 2'd2,
    STATUS_RSVD     = 2'd3
  } status_t;

  // Relation of one stored interval [s,e] to the request range [lo,hi].
  typedef struct packed {
    logic below;     // e + 1 < lo: stays left of an insert
    logic above;     // s > hi + 1: stays right of an insert
    logic disjoint;  // e < lo or s > hi: untouched by an erase
    logic s_lt_lo;   // left piece survives an erase
    logic e_gt_hi;   // right piece survives an erase
    logic holds;     // s <= lo <= e
  } rel_t;

endpackage

FILE: rtl/dis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the two banks of the interval table.
module dis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/dis_cmp.sv
// Entry compare unit: classifies one stored interval against the request
// range and gives its full and clipped lengths. Uses dis_pkg.
module dis_cmp import dis_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] ent_s,
  input  logic [VALUE_BITS-1:0] ent_e,
  input  logic [VALUE_BITS-1:0] lo,
  input  logic [VALUE_BITS-1:0] hi,
  output rel_t                  rel,
  output logic [VALUE_BITS:0]   len_full,
  output logic [VALUE_BITS:0]   len_clip
);

  logic [VALUE_BITS:0]   e_inc;
  logic [VALUE_BITS:0]   hi_inc;
  logic [VALUE_BITS-1:0] clip_a;
  logic [VALUE_BITS-1:0] clip_b;

  assign e_inc  = {1'b0, ent_e} + 1'b1;
  assign hi_inc = {1'b0, hi} + 1'b1;

  always_comb begin
    rel.below    = e_inc < {1'b0, lo};
    rel.above    = {1'b0, ent_s} > hi_inc;
    rel.disjoint = (ent_e < lo) || (ent_s > hi);
    rel.s_lt_lo  = ent_s < lo;
    rel.e_gt_hi  = ent_e > hi;
    rel.holds    = (ent_s <= lo) && (lo <= ent_e);
  end

  assign clip_a   = rel.s_lt_lo ? lo : ent_s;
  assign clip_b   = rel.e_gt_hi ? hi : ent_e;
  assign len_full = {1'b0, ent_e} - {1'b0, ent_s} + 1'b1;
  assign len_clip = {1'b0, clip_b} - {1'b0, clip_a} + 1'b1;

endmodule

FILE: rtl/disjoint_interval_set_top.sv
// Top level of the disjoint interval set: request sequencer, two-bank table
// and result register. Uses dis_pkg, dis_ram and dis_cmp.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   request | in_valid, in_stall, command, range_*     | in
//   result  | out_valid, out_stall, amount .. status   | out
//
// A request walks the stored intervals one per cycle through the shared
// compare unit, but an erase that splits an interval or an insert that lands
// between two holds the walk for an S_PUSH2 state, and a query or mex stops
// at the holding interval. The RAM read port sets the pace.
// Insert and erase rebuild the table into the other bank, and the bank swaps
// only if the result fits; otherwise the old bank stays as it was.
// Reset empties the table at once. in_stall is high while a request is at
// work; a finished result waits in the output register while the next
// request is accepted.
module disjoint_interval_set_top import dis_pkg::*; #(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  localparam int COUNT_W = $clog2(MAX_INTERVALS + 2),
  localparam int IDX_W   = $clog2(MAX_INTERVALS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  logic [VALUE_BITS-1:0] range_low,
  input  logic [VALUE_BITS-1:0] range_high,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS:0]   amount,
  output logic                  is_covered,
  output logic [VALUE_BITS-1:0] cover_low,
  output logic [VALUE_BITS-1:0] cover_high,
  output logic [VALUE_BITS:0]   mex_value,
  output logic [COUNT_W-1:0]    range_count,
  output logic [1:0]            status
);

  localparam int RAM_DEPTH = 2 << IDX_W;
  localparam int RAM_W     = 2 * VALUE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PUSH2,
    S_FINAL,
    S_DONE
  } state_t;

  state_t                state;
  cmd_t                  cmd;
  logic [VALUE_BITS-1:0] lo;
  logic [VALUE_BITS-1:0] hi;
  logic                  rev;
  logic [COUNT_W-1:0]    i;       // entry whose data is on the RAM output
  logic [COUNT_W-1:0]    n;       // entries pushed into the new bank
  logic [COUNT_W-1:0]    total;
  logic                  bank;
  logic                  placed;
  logic [VALUE_BITS-1:0] nl;
  logic [VALUE_BITS-1:0] nr;
  logic [VALUE_BITS:0]   acc;     // merged length (insert) or removed (erase)
  logic [VALUE_BITS-1:0] p2_s;
  logic [VALUE_BITS-1:0] p2_e;
  logic                  found;
  logic [VALUE_BITS-1:0] fs;
  logic [VALUE_BITS-1:0] fe;

  logic [RAM_W-1:0]      rd_data;
  logic [VALUE_BITS-1:0] ent_s;
  logic [VALUE_BITS-1:0] ent_e;
  rel_t                  rel;
  logic [VALUE_BITS:0]   len_full;
  logic [VALUE_BITS:0]   len_clip;

  logic                  push_en;
  logic [VALUE_BITS-1:0] push_s;
  logic [VALUE_BITS-1:0] push_e;
  logic                  need2;
  logic [VALUE_BITS-1:0] sec_s;
  logic [VALUE_BITS-1:0] sec_e;
  logic                  merge_hit;
  logic [COUNT_W-1:0]    i_inc;
  logic [COUNT_W-1:0]    rd_idx;
  logic                  wr_en;
  logic                  fits;
  logic                  commit;
  logic [VALUE_BITS:0]   span;
  status_t               status_next;

  assign ent_s = rd_data[RAM_W-1:VALUE_BITS];
  assign ent_e = rd_data[VALUE_BITS-1:0];
  assign i_inc = i + 1'b1;

  dis_cmp #(.VALUE_BITS(VALUE_BITS)) u_cmp (
    .ent_s    (ent_s),
    .ent_e    (ent_e),
    .lo       (lo),
    .hi       (hi),
    .rel      (rel),
    .len_full (len_full),
    .len_clip (len_clip)
  );

  // Push decode: what goes into the new bank this cycle.
  always_comb begin
    push_en   = 1'b0;
    push_s    = ent_s;
    push_e    = ent_e;
    need2     = 1'b0;
    sec_s     = ent_s;
    sec_e     = ent_e;
    merge_hit = 1'b0;
    unique case (state)
      S_EVAL: begin
        case (cmd)
          CMD_INSERT: begin
            if (rel.below) begin
              push_en = 1'b1;
            end else if (rel.above) begin
              push_en = 1'b1;
              if (!placed) begin
                push_s = nl;
                push_e = nr;
                need2  = 1'b1;
              end
            end else begin
              merge_hit = 1'b1;
            end
          end
          CMD_ERASE: begin
            if (rel.disjoint) begin
              push_en = 1'b1;
            end else begin
              if (rel.s_lt_lo) begin
                push_en = 1'b1;
                push_e  = lo - 1'b1;
              end
              if (rel.e_gt_hi) begin
                if (rel.s_lt_lo) begin
                  need2 = 1'b1;
                  sec_s = hi + 1'b1;
                end else begin
                  push_en = 1'b1;
                  push_s  = hi + 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_PUSH2: begin
        push_en = 1'b1;
        push_s  = p2_s;
        push_e  = p2_e;
      end
      S_FINAL: begin
        if (cmd == CMD_INSERT && !placed) begin
          push_en = 1'b1;
          push_s  = nl;
          push_e  = nr;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:  rd_idx = '0;
      S_EVAL:  rd_idx = i_inc;
      default: rd_idx = i;
    endcase
  end

  // Entries past the table size are dropped; the count still tells overflow.
  assign wr_en = push_en && (n < COUNT_W'(MAX_INTERVALS));

  dis_ram #(.WIDTH(RAM_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({~bank, n[IDX_W-1:0]}),
    .wr_data ({push_s, push_e}),
    .rd_addr ({bank, rd_idx[IDX_W-1:0]}),
    .rd_data (rd_data)
  );

  // Result decode, used in the done state.
  assign fits   = n <= COUNT_W'(MAX_INTERVALS);
  assign commit = !rev && (cmd == CMD_INSERT || cmd == CMD_ERASE) && fits;
  assign span   = {1'b0, nr} - {1'b0, nl} + 1'b1;

  always_comb begin
    if (rev) begin
      status_next = STATUS_REVERSED;
    end else if ((cmd == CMD_INSERT || cmd == CMD_ERASE) && !fits) begin
      status_next = STATUS_FULL;
    end else begin
      status_next = STATUS_OK;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bank      <= 1'b0;
      total     <= '0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        n <= n + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd    <= cmd_t'(command);
            lo     <= range_low;
            hi     <= range_high;
            rev    <= (cmd_t'(command) != CMD_MEX) && (range_low > range_high);
            i      <= '0;
            n      <= '0;
            placed <= 1'b0;
            nl     <= range_low;
            nr     <= range_high;
            acc    <= '0;
            found  <= 1'b0;
            if ((cmd_t'(command) != CMD_MEX) && (range_low > range_high)) begin
              state <= S_DONE;
            end else if (total == '0) begin
              state <= S_FINAL;
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (cmd == CMD_INSERT && rel.above && !placed) begin
            placed <= 1'b1;
          end
          if (merge_hit) begin
            if (ent_s < nl) nl <= ent_s;
            if (ent_e > nr) nr <= ent_e;
            acc <= acc + len_full;
          end
          if (cmd == CMD_ERASE && !rel.disjoint) begin
            acc <= acc + len_clip;
          end
          i <= i_inc;
          if ((cmd == CMD_QUERY || cmd == CMD_MEX) && rel.holds) begin
            found <= 1'b1;
            fs    <= ent_s;
            fe    <= ent_e;
            state <= S_DONE;
          end else if (need2) begin
            p2_s  <= sec_s;
            p2_e  <= sec_e;
            state <= S_PUSH2;
          end else if (i_inc == total) begin
            state <= S_FINAL;
          end
        end
        S_PUSH2: begin
          state <= (i == total) ? S_FINAL : S_EVAL;
        end
        S_FINAL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            status      <= status_next;
            range_count <= commit ? n : total;
            amount      <= '0;
            is_covered  <= 1'b0;
            cover_low   <= '0;
            cover_high  <= '0;
            mex_value   <= '0;
            if (commit) begin
              bank  <= ~bank;
              total <= n;
              amount <= (cmd == CMD_INSERT) ? span - acc : acc;
            end
            if (!rev && cmd == CMD_QUERY && found && hi <= fe) begin
              is_covered <= 1'b1;
              cover_low  <= fs;
              cover_high <= fe;
            end
            if (cmd == CMD_MEX) begin
              mex_value <= found ? {1'b0, fe} + 1'b1 : {1'b0, lo};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
